[hw/rtl/skle_pkg.sv]
// shared types and codes for the sorted key list engine
package skle_pkg;

    // request codes
    localparam logic [2:0] REQ_INSERT    = 3'd0;
    localparam logic [2:0] REQ_REMOVE    = 3'd1;
    localparam logic [2:0] REQ_FIND      = 3'd2;
    localparam logic [2:0] REQ_PEEK_AT   = 3'd3;
    localparam logic [2:0] REQ_PEEK_NEXT = 3'd4;
    localparam logic [2:0] REQ_REWIND    = 3'd5;

    // status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_RANGE    = 3'd1;
    localparam logic [2:0] STAT_NOTFOUND = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_END      = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_REM_FIRST,
        ST_REM_SHIFT,
        ST_FIND,
        ST_PEEK
    } state_t;

endpackage

[hw/rtl/skle_ram.sv]
// generic single write port ram with registered read
module skle_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/sorted_key_list_engine.sv]
// top level of the sorted key list engine: sequencer, compare unit and result registers
//
// usage
// - a request transaction is taken at a rising edge with start high and busy low;
//   req_type selects insert, remove at position, find key, peek at position,
//   peek next or rewind
// - every request gives exactly one result: done is high for one cycle with
//   status, out_key, out_value, out_position and entry_count valid in that cycle;
//   the receiver cannot stall, so a result is never held back
// - entries live in one ram (key and value side by side) and are walked one
//   entry per cycle by a single compare unit, one ram read and one ram write
//   per cycle
// - rewind, full insert, out-of-range and empty cases answer with done in the
//   next cycle and keep busy low
// - insert into a non-empty list walks down from the tail and moves each entry up
//   that the new key passes; remove moves each entry after the removed one down
// - find walks from the head until the first match or the end of the list
// - peek at / peek next: one ram read, then the result
// - busy falls in the cycle where done rises, so the next request can be
//   taken right then
// - reset clears the entry count, the cursor and the sequencer; entry storage
//   is not cleared, only positions below the count are ever read
module sorted_key_list_engine
    import skle_pkg::*;
#(
    parameter int LIST_DEPTH = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        req_type,
    input  logic [KEY_BITS-1:0]               key,
    input  logic [VALUE_BITS-1:0]             value,
    input  logic [$clog2(LIST_DEPTH)-1:0]     position,
    output logic                              done,
    output logic [2:0]                        status,
    output logic [KEY_BITS-1:0]               out_key,
    output logic [VALUE_BITS-1:0]             out_value,
    output logic [$clog2(LIST_DEPTH)-1:0]     out_position,
    output logic [$clog2(LIST_DEPTH+1)-1:0]   entry_count
);

    localparam int PW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int EW = KEY_BITS + VALUE_BITS;

    // sequencer and list state
    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [PW-1:0]       cursor_reg, cursor_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                peek_next_reg, peek_next_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    // result registers
    logic                  done_reg, done_next;
    logic [2:0]            status_reg, status_next;
    logic [KEY_BITS-1:0]   out_key_reg, out_key_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic [PW-1:0]         out_position_reg, out_position_next;
    logic [CW-1:0]         entry_count_reg, entry_count_next;

    // ram port
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    // shared compare unit operands
    logic [KEY_BITS-1:0]   e_key;
    logic [VALUE_BITS-1:0] e_value;
    logic                  at_head;
    logic                  shift_up;
    logic                  key_match;
    logic [CW-1:0]         pos_ext;
    logic [CW-1:0]         cursor_ext;

    skle_ram #(
        .WIDTH (EW),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign e_key      = rd_data[EW-1:VALUE_BITS];
    assign e_value    = rd_data[VALUE_BITS-1:0];
    assign pos_ext    = CW'(position);
    assign cursor_ext = CW'(cursor_reg);
    assign at_head    = (idx_reg == CW'(1));

    // head is passed only by a strictly smaller key, other entries by smaller or equal
    assign shift_up   = at_head ? (key_reg < e_key) : (e_key >= key_reg);
    assign key_match  = (e_key == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            done_reg   <= done_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        idx_reg          <= idx_next;
        peek_next_reg    <= peek_next_next;
        key_reg          <= key_next;
        value_reg        <= value_next;
        status_reg       <= status_next;
        out_key_reg      <= out_key_next;
        out_value_reg    <= out_value_next;
        out_position_reg <= out_position_next;
        entry_count_reg  <= entry_count_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        cursor_next       = cursor_reg;
        idx_next          = idx_reg;
        peek_next_next    = peek_next_reg;
        key_next          = key_reg;
        value_next        = value_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        out_key_next      = out_key_reg;
        out_value_next    = out_value_reg;
        out_position_next = out_position_reg;
        entry_count_next  = entry_count_reg;
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = '0;
        rd_en             = 1'b0;
        rd_addr           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // default answer: no data
                    status_next       = STAT_RANGE;
                    out_key_next      = '0;
                    out_value_next    = '0;
                    out_position_next = '0;
                    case (req_type)
                        REQ_INSERT:
                        begin
                            key_next   = key;
                            value_next = value;
                            if (count_reg == CW'(LIST_DEPTH))
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = '0;
                                wr_data     = {key, value};
                                count_next  = count_reg + CW'(1);
                                done_next   = 1'b1;
                                status_next = STAT_OK;
                            end
                            else
                            begin
                                // walk down from the tail
                                rd_en      = 1'b1;
                                rd_addr    = PW'(count_reg - CW'(1));
                                idx_next   = count_reg;
                                state_next = ST_INS_CMP;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (pos_ext >= count_reg)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = position;
                                idx_next   = pos_ext;
                                state_next = ST_REM_FIRST;
                            end
                        end
                        REQ_FIND:
                        begin
                            key_next = key;
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_NOTFOUND;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = ST_FIND;
                            end
                        end
                        REQ_PEEK_AT:
                        begin
                            if (pos_ext >= count_reg)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_en          = 1'b1;
                                rd_addr        = position;
                                idx_next       = pos_ext;
                                peek_next_next = 1'b0;
                                state_next     = ST_PEEK;
                            end
                        end
                        REQ_PEEK_NEXT:
                        begin
                            // cursor may be stale after removals
                            if (cursor_ext >= count_reg)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_en          = 1'b1;
                                rd_addr        = cursor_reg;
                                idx_next       = cursor_ext;
                                peek_next_next = 1'b1;
                                state_next     = ST_PEEK;
                            end
                        end
                        REQ_REWIND:
                        begin
                            cursor_next = '0;
                            done_next   = 1'b1;
                            status_next = STAT_OK;
                        end
                        default:
                        begin
                            // unknown request type
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_INS_CMP:
            begin
                if (shift_up)
                begin
                    // move entry idx-1 up to idx
                    wr_en    = 1'b1;
                    wr_addr  = PW'(idx_reg);
                    wr_data  = rd_data;
                    idx_next = idx_reg - CW'(1);
                    if (at_head)
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = PW'(idx_reg - CW'(2));
                    end
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = PW'(idx_reg);
                    wr_data     = {key_reg, value_reg};
                    count_next  = count_reg + CW'(1);
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    state_next  = ST_IDLE;
                end
            end

            ST_INS_PUT:
            begin
                // new smallest key goes to the head
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_data     = {key_reg, value_reg};
                count_next  = count_reg + CW'(1);
                done_next   = 1'b1;
                status_next = STAT_OK;
                state_next  = ST_IDLE;
            end

            ST_REM_FIRST:
            begin
                out_key_next      = e_key;
                out_value_next    = e_value;
                out_position_next = PW'(idx_reg);
                if ((idx_reg + CW'(1)) < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = PW'(idx_reg + CW'(1));
                    state_next = ST_REM_SHIFT;
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    state_next  = ST_IDLE;
                end
            end

            ST_REM_SHIFT:
            begin
                // move entry idx+1 down to idx
                wr_en    = 1'b1;
                wr_addr  = PW'(idx_reg);
                wr_data  = rd_data;
                idx_next = idx_reg + CW'(1);
                if ((idx_reg + CW'(2)) < count_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = PW'(idx_reg + CW'(2));
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    state_next  = ST_IDLE;
                end
            end

            ST_FIND:
            begin
                if (key_match)
                begin
                    out_key_next      = e_key;
                    out_value_next    = e_value;
                    out_position_next = PW'(idx_reg);
                    done_next         = 1'b1;
                    status_next       = STAT_OK;
                    state_next        = ST_IDLE;
                end
                else if ((idx_reg + CW'(1)) < count_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = PW'(idx_reg + CW'(1));
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = STAT_NOTFOUND;
                    state_next  = ST_IDLE;
                end
            end

            ST_PEEK:
            begin
                out_key_next      = e_key;
                out_value_next    = e_value;
                out_position_next = PW'(idx_reg);
                done_next         = 1'b1;
                state_next        = ST_IDLE;
                if (!peek_next_reg)
                begin
                    cursor_next = PW'(idx_reg);
                    status_next = STAT_OK;
                end
                else if ((idx_reg + CW'(1)) == count_reg)
                begin
                    // last entry: cursor stays
                    status_next = STAT_END;
                end
                else
                begin
                    cursor_next = PW'(idx_reg + CW'(1));
                    status_next = STAT_OK;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // every result reports the count left after the request
        if (done_next)
        begin
            entry_count_next = count_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_key      = out_key_reg;
    assign out_value    = out_value_reg;
    assign out_position = out_position_reg;
    assign entry_count  = entry_count_reg;

endmodule

[tb/sv/sorted_key_list_engine_checker.sv]
`timescale 1ns / 1ps
// answer checker for the sorted key list engine: list predictor and field compare
module sorted_key_list_engine_checker
    import skle_pkg::*;
#(
    parameter int LIST_DEPTH = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 8,
    parameter int POS_BITS   = $clog2(LIST_DEPTH),
    parameter int CNT_BITS   = $clog2(LIST_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [2:0]            req_type,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [POS_BITS-1:0]   position,
    input  logic                  done,
    input  logic [2:0]            status,
    input  logic [KEY_BITS-1:0]   out_key,
    input  logic [VALUE_BITS-1:0] out_value,
    input  logic [POS_BITS-1:0]   out_position,
    input  logic [CNT_BITS-1:0]   entry_count,
    output int                    error_count,
    output int                    pending,
    output int                    checked_count,
    output int                    full_count,
    output int                    end_count
);

    typedef struct packed {
        logic [2:0]            req;
        logic [2:0]            status;
        logic [KEY_BITS-1:0]   rkey;
        logic [VALUE_BITS-1:0] rval;
        logic [POS_BITS-1:0]   rpos;
        logic [CNT_BITS-1:0]   rcount;
    } list_answer_t;

    logic [KEY_BITS-1:0]   list_keys [LIST_DEPTH];
    logic [VALUE_BITS-1:0] list_vals [LIST_DEPTH];
    int                    held_n;
    int                    cursor;
    list_answer_t          answer_q [$];

    initial
    begin
        error_count   = 0;
        pending       = 0;
        checked_count = 0;
        full_count    = 0;
        end_count     = 0;
    end

    // applies one request to the list copy and builds its answer
    task automatic predict_answer(input logic [2:0] rt, input logic [KEY_BITS-1:0] k,
                                  input logic [VALUE_BITS-1:0] v,
                                  input logic [POS_BITS-1:0] p,
                                  output list_answer_t a);
        int  slot;
        int  i;
        bit  found;
        a = '0;
        a.req = rt;
        a.status = STAT_RANGE;
        case (rt)
            REQ_INSERT:
            begin
                if (held_n >= LIST_DEPTH)
                    a.status = STAT_FULL;
                else
                begin
                    // equal to head goes after it, else before the first later key that is equal or larger
                    if (held_n == 0 || k < list_keys[0])
                        slot = 0;
                    else
                    begin
                        slot = held_n;
                        found = 0;
                        for (i = 1; i < held_n; i++)
                            if (!found && list_keys[i] >= k)
                            begin
                                slot = i;
                                found = 1;
                            end
                    end
                    for (i = held_n; i > slot; i--)
                    begin
                        list_keys[i] = list_keys[i-1];
                        list_vals[i] = list_vals[i-1];
                    end
                    list_keys[slot] = k;
                    list_vals[slot] = v;
                    held_n++;
                    a.status = STAT_OK;
                end
            end
            REQ_REMOVE:
            begin
                if (int'(p) < held_n)
                begin
                    a.status = STAT_OK;
                    a.rkey = list_keys[p];
                    a.rval = list_vals[p];
                    a.rpos = p;
                    for (i = int'(p); i + 1 < held_n; i++)
                    begin
                        list_keys[i] = list_keys[i+1];
                        list_vals[i] = list_vals[i+1];
                    end
                    held_n--;
                end
            end
            REQ_FIND:
            begin
                a.status = STAT_NOTFOUND;
                found = 0;
                for (i = 0; i < held_n; i++)
                    if (!found && list_keys[i] == k)
                    begin
                        found = 1;
                        a.status = STAT_OK;
                        a.rkey = list_keys[i];
                        a.rval = list_vals[i];
                        a.rpos = POS_BITS'(i);
                    end
            end
            REQ_PEEK_AT:
            begin
                if (int'(p) < held_n)
                begin
                    cursor = p;
                    a.status = STAT_OK;
                    a.rkey = list_keys[p];
                    a.rval = list_vals[p];
                    a.rpos = p;
                end
            end
            REQ_PEEK_NEXT:
            begin
                // a stale cursor past the end reads as out of range
                if (cursor < held_n)
                begin
                    a.rkey = list_keys[cursor];
                    a.rval = list_vals[cursor];
                    a.rpos = POS_BITS'(cursor);
                    if (cursor + 1 == held_n)
                        a.status = STAT_END;
                    else
                    begin
                        a.status = STAT_OK;
                        cursor++;
                    end
                end
            end
            REQ_REWIND:
            begin
                cursor = 0;
                a.status = STAT_OK;
            end
            default:
                a.status = STAT_RANGE;
        endcase
        a.rcount = CNT_BITS'(held_n);
    endtask

    task automatic compare_field(input string name, input logic [2:0] rt,
                                 input logic [31:0] exp_v, input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            error_count++;
            $display("%0t: request %0d, %s mismatch: expected 0x%0h actual 0x%0h",
                     $time, rt, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_answer_t a;
        if (!rst_n)
        begin
            held_n = 0;
            cursor = 0;
            answer_q.delete();
        end
        else
        begin
            // answers first: the answer of this edge belongs to an earlier request
            if (done)
            begin
                if (answer_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: answer with none expected: status %0d key 0x%0h",
                             $time, status, out_key);
                end
                else
                begin
                    a = answer_q.pop_front();
                    compare_field("status", a.req, a.status, status);
                    compare_field("out_key", a.req, a.rkey, out_key);
                    compare_field("out_value", a.req, a.rval, out_value);
                    compare_field("out_position", a.req, a.rpos, out_position);
                    compare_field("entry_count", a.req, a.rcount, entry_count);
                    checked_count++;
                    if (a.status == STAT_FULL)
                        full_count++;
                    if (a.status == STAT_END)
                        end_count++;
                end
            end
            if (start && !busy)
            begin
                predict_answer(req_type, key, value, position, a);
                answer_q.push_back(a);
            end
        end
        pending = answer_q.size();
    end

endmodule

[tb/sv/sorted_key_list_engine_tb.sv]
`timescale 1ns / 1ps
// testbench top for the sorted key list engine: reset, request stimulus and verdict
module sorted_key_list_engine_tb;
    import skle_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 8;
    localparam int POS_BITS   = $clog2(LIST_DEPTH);
    localparam int CNT_BITS   = $clog2(LIST_DEPTH + 1);

    // request codes the block does not define, answered as out of range
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    // stimulus shape and run bounds
    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = LIST_DEPTH + 8;
    localparam int POOL_SIZE    = 8;

    // random phase flavors: fill the list, drain it, or mix freely
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [2:0]            req_type;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [POS_BITS-1:0]   position;
    logic                  done;
    logic [2:0]            status;
    logic [KEY_BITS-1:0]   out_key;
    logic [VALUE_BITS-1:0] out_value;
    logic [POS_BITS-1:0]   out_position;
    logic [CNT_BITS-1:0]   entry_count;

    int error_count;
    int pending;
    int checked_count;
    int full_count;
    int end_count;
    int cycle_count = 0;
    int sent_count = 0;
    int directed_count = 0;

    // keys recently inserted, reused so finds hit and equal keys pile up
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
    int                  pool_fill = 0;
    int                  pool_wr = 0;

    sorted_key_list_engine #(
        .LIST_DEPTH (LIST_DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .key          (key),
        .value        (value),
        .position     (position),
        .done         (done),
        .status       (status),
        .out_key      (out_key),
        .out_value    (out_value),
        .out_position (out_position),
        .entry_count  (entry_count)
    );

    // watches both channels, predicts every answer and counts mismatches
    sorted_key_list_engine_checker #(
        .LIST_DEPTH (LIST_DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .key           (key),
        .value         (value),
        .position      (position),
        .done          (done),
        .status        (status),
        .out_key       (out_key),
        .out_value     (out_value),
        .out_position  (out_position),
        .entry_count   (entry_count),
        .error_count   (error_count),
        .pending       (pending),
        .checked_count (checked_count),
        .full_count    (full_count),
        .end_count     (end_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake or a lost answer ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding", cycle_count, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one request transaction: present it and hold it until the block takes it
    // start stays high on return so back-to-back requests never drop it
    task automatic send_request(input logic [2:0] rt, input logic [KEY_BITS-1:0] k,
                                input logic [VALUE_BITS-1:0] v,
                                input logic [POS_BITS-1:0] p);
        start    <= 1'b1;
        req_type <= rt;
        key      <= k;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_count++;
        if (rt == REQ_INSERT)
        begin
            key_pool[pool_wr] = k;
            pool_wr = (pool_wr + 1) % POOL_SIZE;
            if (pool_fill < POOL_SIZE)
                pool_fill++;
        end
    endtask

    // gap between bursts, with junk on the payload while start is low
    task automatic pause_sender(input int cycles);
        start    <= 1'b0;
        req_type <= 3'($urandom);
        key      <= KEY_BITS'($urandom);
        value    <= VALUE_BITS'($urandom);
        position <= POS_BITS'($urandom);
        repeat (cycles)
            @(posedge clk);
    endtask

    // one random request whose mix of operations follows the phase flavor
    task automatic random_request(input int mode);
        int                    pick;
        int                    kind;
        logic [2:0]            rt;
        logic [KEY_BITS-1:0]   k;
        logic [VALUE_BITS-1:0] v;
        logic [POS_BITS-1:0]   p;
        pick = $urandom_range(0, 99);
        // cumulative weights: insert, remove, find, peek next, peek at, rewind, spare
        case (mode)
            MODE_FILL:
                rt = pick < 70 ? REQ_INSERT : pick < 74 ? REQ_REMOVE : pick < 84 ? REQ_FIND :
                     pick < 91 ? REQ_PEEK_NEXT : pick < 96 ? REQ_PEEK_AT :
                     pick < 99 ? REQ_REWIND : REQ_SPARE_A;
            MODE_DRAIN:
                rt = pick < 15 ? REQ_INSERT : pick < 60 ? REQ_REMOVE : pick < 70 ? REQ_FIND :
                     pick < 82 ? REQ_PEEK_NEXT : pick < 90 ? REQ_PEEK_AT :
                     pick < 97 ? REQ_REWIND : REQ_SPARE_A;
            default:
                rt = pick < 35 ? REQ_INSERT : pick < 55 ? REQ_REMOVE : pick < 70 ? REQ_FIND :
                     pick < 83 ? REQ_PEEK_NEXT : pick < 92 ? REQ_PEEK_AT :
                     pick < 98 ? REQ_REWIND : REQ_SPARE_A;
        endcase
        if (rt == REQ_SPARE_A && $urandom_range(0, 1) == 1)
            rt = REQ_SPARE_B;
        // keys: reuse, a narrow band for collisions, or anything
        kind = $urandom_range(0, 9);
        if (kind < 4 && pool_fill > 0)
            k = key_pool[$urandom_range(0, pool_fill - 1)];
        else if (kind < 7)
            k = KEY_BITS'($urandom_range(0, 15));
        else
            k = KEY_BITS'($urandom);
        v = VALUE_BITS'($urandom);
        // positions mostly near the head, where a short list has entries
        if ($urandom_range(0, 1) == 1)
            p = POS_BITS'($urandom_range(0, LIST_DEPTH - 1));
        else
            p = POS_BITS'($urandom_range(0, 3));
        send_request(rt, k, v, p);
    endtask

    initial
    begin
        int i;
        int mode;
        int phase_left;
        int burst_left;

        mode       = MODE_MIX;
        phase_left = 0;
        burst_left = 0;

        rst_n    <= 1'b0;
        start    <= 1'b0;
        req_type <= REQ_REWIND;
        key      <= '0;
        value    <= '0;
        position <= '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every read flavor must report out of range or not found
        send_request(REQ_PEEK_NEXT, '0, '0, '0);
        send_request(REQ_REMOVE, '0, '0, '0);
        send_request(REQ_FIND, '0, '0, '0);
        send_request(REQ_PEEK_AT, '1, '1, '1);
        send_request(REQ_REWIND, '1, '1, '1);
        send_request(REQ_SPARE_A, '0, '0, '0);
        send_request(REQ_SPARE_B, '1, '1, '1);
        pause_sender(2);

        // head rules: equal to head goes after it, smaller goes in front
        send_request(REQ_INSERT, 16'h8000, 8'hAA, '0);
        send_request(REQ_INSERT, 16'h8000, 8'h55, '0);
        send_request(REQ_INSERT, 16'h0000, 8'h00, '0);
        send_request(REQ_INSERT, 16'hFFFF, 8'hFF, '1);
        // now equal to a non-head key: lands before the first equal one
        send_request(REQ_INSERT, 16'h8000, 8'h11, '0);
        send_request(REQ_FIND, 16'h8000, '0, '0);
        send_request(REQ_FIND, 16'h1234, '0, '0);

        // cursor walk up to the last entry, then a stale cursor after removals
        send_request(REQ_PEEK_AT, '0, '0, 4'd3);
        send_request(REQ_PEEK_NEXT, '0, '0, '0);
        send_request(REQ_PEEK_NEXT, '0, '0, '0);
        send_request(REQ_REMOVE, '0, '0, '1);
        send_request(REQ_REMOVE, '0, '0, 4'd4);
        send_request(REQ_REMOVE, '0, '0, '0);
        send_request(REQ_PEEK_NEXT, '0, '0, '0);
        send_request(REQ_REWIND, '0, '0, '0);
        send_request(REQ_PEEK_NEXT, '0, '0, '0);
        directed_count = sent_count;

        // random part: phases of fill, drain and mix, sent in bursts with gaps
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (phase_left == 0)
            begin
                mode = $urandom_range(MODE_FILL, MODE_MIX);
                phase_left = $urandom_range(15, 40);
            end
            phase_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                // some bursts follow straight on with no gap at all
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 6));
            end
            burst_left--;
            random_request(mode);
        end
        start <= 1'b0;

        // let every predicted answer arrive, then watch for strays
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("covered %0d request transactions (%0d directed), %0d answers compared",
                 sent_count, directed_count, checked_count);
        $display("list-full answers seen: %0d, end-of-list answers seen: %0d",
                 full_count, end_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
